// ===== rtl/core/pump_guard_controller_defines.svh =====
// ----------------------------------------------------------------------------
// pump_guard_controller_defines
// Assertion macros shared by the pump guard checker
// ----------------------------------------------------------------------------
`ifndef PUMP_GUARD_CONTROLLER_DEFINES_SVH
`define PUMP_GUARD_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PGC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pump guard check failed");

// next-cycle implication, disabled during reset
`define PGC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pump guard check failed");

`endif

// ===== rtl/core/pgc_pkg.sv =====
// ----------------------------------------------------------------------------
// pgc_pkg
// Types and constants of the refill pump guard
// ----------------------------------------------------------------------------
package pgc_pkg;

  // configuration word and index widths
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  // default elapsed counter width
  localparam int TIMER_BITS_DEF = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_DELAY = 2'd1;

  // register reset values
  localparam logic [CFG_W-1:0] RUN_LIMIT_RST   = 24'd60000;
  localparam logic [CFG_W-1:0] START_DELAY_RST = 24'd5000;

  // item opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CMD  = 1'b1;

  // one input word
  typedef struct packed {
    logic opcode;
    logic sensor_level;
    logic service_mode;
    logic water_alarm;
    logic alarm_switch_on;
  } pgc_item_t;

  // one result word
  typedef struct packed {
    logic pump_drive;
    logic start_pending;
    logic lock_active;
    logic alarm_indicator;
    logic water_seen;
    logic beep_pulse;
  } pgc_result_t;

  // limits held by the configuration registers
  typedef struct packed {
    logic [CFG_W-1:0] run_limit;
    logic [CFG_W-1:0] start_delay;
  } pgc_limits_t;

endpackage

// ===== rtl/core/pgc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pgc_cfg_regs
// Run limit and start delay registers behind the configuration port
// ----------------------------------------------------------------------------
module pgc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pgc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pgc_pkg::CFG_W-1:0]        cfg_data,
  output pgc_pkg::pgc_limits_t             limits
);

  pgc_pkg::pgc_limits_t limits_r, limits_nxt;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // index decode, unknown indexes are dropped
  always_comb begin
    limits_nxt = limits_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        pgc_pkg::REG_RUN_LIMIT:   limits_nxt.run_limit   = cfg_data;
        pgc_pkg::REG_START_DELAY: limits_nxt.start_delay = cfg_data;
        default:                  limits_nxt = limits_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.run_limit   <= pgc_pkg::RUN_LIMIT_RST;
      limits_r.start_delay <= pgc_pkg::START_DELAY_RST;
    end else begin
      limits_r <= limits_nxt;
    end
  end

  assign limits = limits_r;

endmodule

// ===== rtl/core/pgc_in_reg.sv =====
// ----------------------------------------------------------------------------
// pgc_in_reg
// Input register, refilled in the cycle its word moves on
// ----------------------------------------------------------------------------
module pgc_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pgc_pkg::pgc_item_t in_item,
  output logic               item_valid,
  input  logic               item_take,
  output pgc_pkg::pgc_item_t item
);

  logic               valid_r, valid_nxt;
  pgc_pkg::pgc_item_t item_r;

  // free when empty or when the held word leaves this cycle
  assign in_ready = !valid_r || item_take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== rtl/core/pgc_guard_core.sv =====
// ----------------------------------------------------------------------------
// pgc_guard_core
// Guard state and the per-word update of pump, delay, lock and alarm
// ----------------------------------------------------------------------------
module pgc_guard_core #(
  parameter int TIMER_BITS = pgc_pkg::TIMER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  pgc_pkg::pgc_item_t   item,
  input  pgc_pkg::pgc_limits_t limits,
  output pgc_pkg::pgc_result_t result
);

  localparam int CMP_W = (TIMER_BITS > pgc_pkg::CFG_W) ? TIMER_BITS : pgc_pkg::CFG_W;

  logic                  pump_running_r, pump_running_nxt;
  logic                  delay_armed_r, delay_armed_nxt;
  logic                  safety_locked_r, safety_locked_nxt;
  logic                  alarm_shown_r, alarm_shown_nxt;
  logic [TIMER_BITS-1:0] run_elapsed_r, run_elapsed_nxt;
  logic [TIMER_BITS-1:0] delay_elapsed_r, delay_elapsed_nxt;

  logic [TIMER_BITS-1:0] run_inc;
  logic [TIMER_BITS-1:0] delay_inc;
  logic                  water;
  logic                  over_run;
  logic                  delay_done;
  logic                  beep;

  // saturating counter advance
  assign run_inc   = (&run_elapsed_r)   ? run_elapsed_r   : run_elapsed_r + 1'b1;
  assign delay_inc = (&delay_elapsed_r) ? delay_elapsed_r : delay_elapsed_r + 1'b1;

  // sensor pin is low when water is present
  assign water = !item.sensor_level;

  // limit compares at a common width
  assign over_run   = CMP_W'(run_inc) > CMP_W'(limits.run_limit);
  assign delay_done = CMP_W'(delay_inc) >= CMP_W'(limits.start_delay);

  // priority checks for a tick, lock reset for a command with the alarm switch off
  always_comb begin
    pump_running_nxt  = pump_running_r;
    delay_armed_nxt   = delay_armed_r;
    safety_locked_nxt = safety_locked_r;
    alarm_shown_nxt   = alarm_shown_r;
    run_elapsed_nxt   = run_elapsed_r;
    delay_elapsed_nxt = delay_elapsed_r;
    beep              = 1'b0;
    if (item.opcode == pgc_pkg::OP_CMD) begin
      if (!item.alarm_switch_on) begin
        safety_locked_nxt = 1'b0;
        alarm_shown_nxt   = 1'b0;
        beep              = 1'b1;
      end
    end else begin
      run_elapsed_nxt   = run_inc;
      delay_elapsed_nxt = delay_inc;
      if (item.service_mode) begin
        // service holds the pump off, an armed delay stays armed
        if (pump_running_r) begin
          pump_running_nxt = 1'b0;
          run_elapsed_nxt  = '0;
        end
      end else if (pump_running_r && over_run) begin
        // over-run trips the lock
        pump_running_nxt  = 1'b0;
        run_elapsed_nxt   = '0;
        safety_locked_nxt = 1'b1;
        alarm_shown_nxt   = 1'b1;
      end else if (safety_locked_r || item.water_alarm) begin
        if (pump_running_r) begin
          pump_running_nxt = 1'b0;
          run_elapsed_nxt  = '0;
        end
      end else if (!water && pump_running_r) begin
        // ran dry
        pump_running_nxt = 1'b0;
        run_elapsed_nxt  = '0;
        delay_armed_nxt  = 1'b0;
        alarm_shown_nxt  = 1'b1;
      end else if (water && !pump_running_r && !delay_armed_r) begin
        // arming tick does nothing more
        delay_armed_nxt   = 1'b1;
        delay_elapsed_nxt = '0;
      end else if (delay_armed_r && !pump_running_r && delay_done) begin
        pump_running_nxt = 1'b1;
        run_elapsed_nxt  = '0;
        delay_armed_nxt  = 1'b0;
      end
    end
  end

  // state moves only with a word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pump_running_r  <= 1'b0;
      delay_armed_r   <= 1'b0;
      safety_locked_r <= 1'b0;
      alarm_shown_r   <= 1'b0;
      run_elapsed_r   <= '0;
      delay_elapsed_r <= '0;
    end else if (step) begin
      pump_running_r  <= pump_running_nxt;
      delay_armed_r   <= delay_armed_nxt;
      safety_locked_r <= safety_locked_nxt;
      alarm_shown_r   <= alarm_shown_nxt;
      run_elapsed_r   <= run_elapsed_nxt;
      delay_elapsed_r <= delay_elapsed_nxt;
    end
  end

  // result shows the state after the word
  always_comb begin
    result.pump_drive      = pump_running_nxt;
    result.start_pending   = delay_armed_nxt;
    result.lock_active     = safety_locked_nxt;
    result.alarm_indicator = alarm_shown_nxt;
    result.water_seen      = (item.opcode == pgc_pkg::OP_TICK) && water;
    result.beep_pulse      = beep;
  end

endmodule

// ===== rtl/core/pgc_out_reg.sv =====
// ----------------------------------------------------------------------------
// pgc_out_reg
// Result register, loaded when empty or while the previous word is being taken
// ----------------------------------------------------------------------------
module pgc_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  output logic                 res_take,
  input  pgc_pkg::pgc_result_t res,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pgc_pkg::pgc_result_t out_res
);

  logic                 valid_r, valid_nxt;
  pgc_pkg::pgc_result_t res_r;

  // load when empty or drained this cycle
  assign res_take = res_valid && (!valid_r || out_ready);

  always_comb begin
    valid_nxt = valid_r;
    if (res_take) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (res_take) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== rtl/core/pump_guard_controller.sv =====
// ----------------------------------------------------------------------------
// pump_guard_controller
// Refill pump guard: run-time lock, dry-run stop and delayed start per word
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        input      in_valid / in_ready    opcode, sensor, mode, alarm, switch
//  out       output     out_valid / out_ready  pump, pending, lock, alarm, water, beep
//  cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  one word per cycle unless the output stalls; results are registered
//  the guard update is one pass of compare-and-select between the input
//  register and the result register
//  synchronous reset clears the guard state and sets the limit defaults
//  a stalled output holds its result while the input register keeps one more word
// ----------------------------------------------------------------------------
module pump_guard_controller #(
  parameter int TIMER_BITS = pgc_pkg::TIMER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic                          in_sensor_level,
  input  logic                          in_service_mode,
  input  logic                          in_water_alarm,
  input  logic                          in_alarm_switch_on,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_pump_drive,
  output logic                          out_start_pending,
  output logic                          out_lock_active,
  output logic                          out_alarm_indicator,
  output logic                          out_water_seen,
  output logic                          out_beep_pulse,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pgc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pgc_pkg::CFG_W-1:0]     cfg_data
);

  pgc_pkg::pgc_item_t   in_item;
  pgc_pkg::pgc_item_t   item;
  pgc_pkg::pgc_limits_t limits;
  pgc_pkg::pgc_result_t res;
  pgc_pkg::pgc_result_t out_res;
  logic                 item_valid;
  logic                 step;

  // pack the input word
  assign in_item.opcode          = in_opcode;
  assign in_item.sensor_level    = in_sensor_level;
  assign in_item.service_mode    = in_service_mode;
  assign in_item.water_alarm     = in_water_alarm;
  assign in_item.alarm_switch_on = in_alarm_switch_on;

  pgc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .limits    (limits)
  );

  pgc_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (step),
    .item       (item)
  );

  pgc_guard_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item),
    .limits (limits),
    .result (res)
  );

  pgc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (item_valid),
    .res_take  (step),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // unpack the result word
  assign out_pump_drive      = out_res.pump_drive;
  assign out_start_pending   = out_res.start_pending;
  assign out_lock_active     = out_res.lock_active;
  assign out_alarm_indicator = out_res.alarm_indicator;
  assign out_water_seen      = out_res.water_seen;
  assign out_beep_pulse      = out_res.beep_pulse;

endmodule

// ===== rtl/core/pgc_checker.sv =====
// ----------------------------------------------------------------------------
// pgc_checker
// Port-level checks on the pump guard, bound to the top level
// ----------------------------------------------------------------------------
`include "pump_guard_controller_defines.svh"

module pgc_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_pump_drive,
  input logic out_start_pending,
  input logic out_lock_active,
  input logic out_alarm_indicator,
  input logic out_water_seen,
  input logic out_beep_pulse
);

  logic [5:0] out_word;

  // result word as seen on the ports
  assign out_word = {out_pump_drive, out_start_pending, out_lock_active,
                     out_alarm_indicator, out_water_seen, out_beep_pulse};

  // a stalled result word holds
  `PGC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word))

  // a confirmed reset leaves lock and alarm clear
  `PGC_ASSERT_NOW(a_beep_clears, clk, rst_n, out_valid && out_beep_pulse, !out_lock_active && !out_alarm_indicator)

  // water is only decoded on ticks, beep only on commands
  `PGC_ASSERT_NOW(a_tick_or_cmd, clk, rst_n, out_valid && out_water_seen, !out_beep_pulse)

  // a running pump is never locked or still waiting to start
  `PGC_ASSERT_NOW(a_run_clean, clk, rst_n, out_valid && out_pump_drive, !out_lock_active && !out_start_pending)

endmodule

bind pump_guard_controller pgc_checker u_pgc_checker (.*);

// ===== bench/pump_guard_controller_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pump_guard_controller_tb
// Self-checking bench for the refill pump guard: a software copy of the guard
// state predicts every result word; directed and randomised tick and command
// words are pushed through several limit settings and handshake patterns
// ----------------------------------------------------------------------------
module pump_guard_controller_tb;

  localparam int TIMER_W     = pgc_pkg::TIMER_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [pgc_pkg::CFG_W-1:0] LIMIT_MAX = '1;

  // guard state copy, limits and the queue of results still owed by the block
  class guard_tracker;
    logic [pgc_pkg::CFG_W-1:0] run_limit;
    logic [pgc_pkg::CFG_W-1:0] start_delay;
    logic                      pump_on;
    logic                      armed;
    logic                      locked;
    logic                      alarm;
    logic [TIMER_W-1:0]        run_elapsed;
    logic [TIMER_W-1:0]        delay_elapsed;
    pgc_pkg::pgc_result_t      due_results[$];
    int                        errors;

    function new();
      run_limit     = pgc_pkg::RUN_LIMIT_RST;
      start_delay   = pgc_pkg::START_DELAY_RST;
      pump_on       = 1'b0;
      armed         = 1'b0;
      locked        = 1'b0;
      alarm         = 1'b0;
      run_elapsed   = '0;
      delay_elapsed = '0;
      errors        = 0;
    endfunction

    function void set_limit(logic [pgc_pkg::CFG_IDX_W-1:0] idx,
                            logic [pgc_pkg::CFG_W-1:0] value);
      if (idx == pgc_pkg::REG_RUN_LIMIT) begin
        run_limit = value;
      end else if (idx == pgc_pkg::REG_START_DELAY) begin
        start_delay = value;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void halt();
      pump_on     = 1'b0;
      run_elapsed = '0;
    endfunction

    // advance the guard by one accepted word and queue its result
    function void note_word(pgc_pkg::pgc_item_t w);
      pgc_pkg::pgc_result_t r;
      logic                 water;
      r     = '0;
      water = !w.sensor_level;
      if (w.opcode == pgc_pkg::OP_CMD) begin
        if (!w.alarm_switch_on) begin
          locked       = 1'b0;
          alarm        = 1'b0;
          r.beep_pulse = 1'b1;
        end
      end else begin
        r.water_seen = water;
        // saturating elapsed counters
        if (run_elapsed != '1) run_elapsed = run_elapsed + 1'b1;
        if (delay_elapsed != '1) delay_elapsed = delay_elapsed + 1'b1;
        // checks in priority order
        if (w.service_mode) begin
          if (pump_on) halt();
        end else if (pump_on && run_elapsed > run_limit) begin
          halt();
          locked = 1'b1;
          alarm  = 1'b1;
        end else if (locked || w.water_alarm) begin
          if (pump_on) halt();
        end else if (!water && pump_on) begin
          halt();
          armed = 1'b0;
          alarm = 1'b1;
        end else if (water && !pump_on && !armed) begin
          armed         = 1'b1;
          delay_elapsed = '0;
        end else if (armed && !pump_on && delay_elapsed >= start_delay) begin
          pump_on     = 1'b1;
          run_elapsed = '0;
          armed       = 1'b0;
        end
      end
      r.pump_drive      = pump_on;
      r.start_pending   = armed;
      r.lock_active     = locked;
      r.alarm_indicator = alarm;
      due_results.push_back(r);
    endfunction

    // compare one result word with the oldest one owed
    function void check_result(pgc_pkg::pgc_result_t got);
      pgc_pkg::pgc_result_t want;
      string                names [6];
      names = '{"pump_drive", "start_pending", "lock_active",
                "alarm_indicator", "water_seen", "beep_pulse"};
      if (due_results.size() == 0) begin
        $error("result word %b with nothing outstanding", got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      for (int i = 0; i < 6; i++) begin
        if (got[5-i] !== want[5-i]) begin
          $error("%s: expected %0b, got %0b", names[i], want[5-i], got[5-i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic                          in_opcode;
  logic                          in_sensor_level;
  logic                          in_service_mode;
  logic                          in_water_alarm;
  logic                          in_alarm_switch_on;
  logic                          out_valid;
  logic                          out_ready;
  logic                          out_pump_drive;
  logic                          out_start_pending;
  logic                          out_lock_active;
  logic                          out_alarm_indicator;
  logic                          out_water_seen;
  logic                          out_beep_pulse;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [pgc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pgc_pkg::CFG_W-1:0]     cfg_data;

  guard_tracker guard;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           hold_off_cycles;
  int           cycle_count;

  pump_guard_controller dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_sensor_level     (in_sensor_level),
    .in_service_mode     (in_service_mode),
    .in_water_alarm      (in_water_alarm),
    .in_alarm_switch_on  (in_alarm_switch_on),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pump_drive      (out_pump_drive),
    .out_start_pending   (out_start_pending),
    .out_lock_active     (out_lock_active),
    .out_alarm_indicator (out_alarm_indicator),
    .out_water_seen      (out_water_seen),
    .out_beep_pulse      (out_beep_pulse),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      guard.check_result({out_pump_drive, out_start_pending, out_lock_active,
                          out_alarm_indicator, out_water_seen, out_beep_pulse});
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic pgc_pkg::pgc_item_t tick_word(logic sensor, logic service,
                                                   logic ext_alarm);
    pgc_pkg::pgc_item_t w;
    w = '{opcode: pgc_pkg::OP_TICK, sensor_level: sensor, service_mode: service,
          water_alarm: ext_alarm, alarm_switch_on: 1'($urandom_range(1))};
    return w;
  endfunction

  function automatic pgc_pkg::pgc_item_t command_word(logic switch_on);
    pgc_pkg::pgc_item_t w;
    w = '{opcode: pgc_pkg::OP_CMD, sensor_level: 1'($urandom_range(1)),
          service_mode: 1'($urandom_range(1)), water_alarm: 1'($urandom_range(1)),
          alarm_switch_on: switch_on};
    return w;
  endfunction

  // offer one word, with an optional random gap first, and wait for it to go
  task automatic send_word(pgc_pkg::pgc_item_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid           <= 1'b1;
    in_opcode          <= w.opcode;
    in_sensor_level    <= w.sensor_level;
    in_service_mode    <= w.service_mode;
    in_water_alarm     <= w.water_alarm;
    in_alarm_switch_on <= w.alarm_switch_on;
    do @(posedge clk); while (!in_ready);
    guard.note_word(w);
  endtask

  // stop sending and wait for every owed result
  task automatic drain();
    in_valid <= 1'b0;
    while (guard.pending() != 0) @(posedge clk);
  endtask

  // write both limit registers back to back
  task automatic write_limits(logic [pgc_pkg::CFG_W-1:0] run,
                              logic [pgc_pkg::CFG_W-1:0] delay);
    cfg_valid <= 1'b1;
    cfg_index <= pgc_pkg::REG_RUN_LIMIT;
    cfg_data  <= run;
    do @(posedge clk); while (!cfg_ready);
    guard.set_limit(pgc_pkg::REG_RUN_LIMIT, run);
    cfg_index <= pgc_pkg::REG_START_DELAY;
    cfg_data  <= delay;
    do @(posedge clk); while (!cfg_ready);
    guard.set_limit(pgc_pkg::REG_START_DELAY, delay);
    cfg_valid <= 1'b0;
  endtask

  // mostly wet ticks with the odd dry sample, service, alarm and command word
  task automatic run_random(int count);
    pgc_pkg::pgc_item_t w;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 8) begin
        w = command_word(1'($urandom_range(1)));
      end else begin
        w = tick_word($urandom_range(99) < 15, $urandom_range(99) < 8,
                      $urandom_range(99) < 8);
      end
      send_word(w);
    end
  endtask

  // stimulus
  initial begin
    logic [pgc_pkg::CFG_W-1:0] run_lim;
    logic [pgc_pkg::CFG_W-1:0] delay_lim;
    guard              = new();
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_off_cycles    = 0;
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_opcode          <= pgc_pkg::OP_TICK;
    in_sensor_level    <= 1'b1;
    in_service_mode    <= 1'b0;
    in_water_alarm     <= 1'b0;
    in_alarm_switch_on <= 1'b1;
    cfg_valid          <= 1'b0;
    cfg_index          <= pgc_pkg::REG_RUN_LIMIT;
    cfg_data           <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limits: the delay is long, so words only arm
    run_random(12);
    drain();

    // short limits: arm, delayed start, over-run lock, reset, service stop, dry tick
    write_limits(24'd3, 24'd2);
    send_word(command_word(1'b1));
    send_word(command_word(1'b0));
    send_word(tick_word(1'b1, 1'b0, 1'b0));
    send_word(tick_word(1'b0, 1'b0, 1'b0));
    send_word(tick_word(1'b0, 1'b0, 1'b0));
    send_word(tick_word(1'b0, 1'b0, 1'b0));
    repeat (4) send_word(tick_word(1'b0, 1'b0, 1'b0));
    send_word(tick_word(1'b0, 1'b0, 1'b0));
    send_word(tick_word(1'b0, 1'b0, 1'b1));
    send_word(command_word(1'b0));
    send_word(tick_word(1'b0, 1'b0, 1'b0));
    send_word(tick_word(1'b0, 1'b1, 1'b0));
    send_word(tick_word(1'b0, 1'b0, 1'b0));
    send_word(tick_word(1'b0, 1'b1, 1'b0));
    send_word(tick_word(1'b1, 1'b0, 1'b0));
    drain();

    // zero limits: start on the tick after arming, lock on the first run tick
    write_limits(24'd0, 24'd0);
    send_word(tick_word(1'b0, 1'b0, 1'b0));
    send_word(tick_word(1'b0, 1'b0, 1'b0));
    send_word(tick_word(1'b0, 1'b0, 1'b0));
    send_word(command_word(1'b0));
    send_word(tick_word(1'b0, 1'b0, 1'b0));
    send_word(tick_word(1'b0, 1'b0, 1'b0));
    drain();

    // random phases over limit settings and handshake patterns
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       begin run_lim = 24'd4;     delay_lim = 24'd1;     end
        1:       begin run_lim = LIMIT_MAX; delay_lim = 24'd0;     end
        2:       begin run_lim = 24'd0;     delay_lim = LIMIT_MAX; end
        4:       begin run_lim = 24'd1;     delay_lim = 24'd1;     end
        5:       begin run_lim = LIMIT_MAX; delay_lim = LIMIT_MAX; end
        default: begin
          run_lim   = pgc_pkg::CFG_W'($urandom_range(15));
          delay_lim = pgc_pkg::CFG_W'($urandom_range(5));
        end
      endcase
      write_limits(run_lim, delay_lim);
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      // long receiver hold-off while the sender keeps offering
      if (p == 0) hold_off_cycles = 300;
      run_random(55);
      drain();
    end

    repeat (10) @(posedge clk);
    if (guard.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
